// ----- src/sigmoid_lut_interpolator_defines.svh -----
// assertion macros for the sigmoid table interpolator
`ifndef SIGMOID_LUT_INTERPOLATOR_DEFINES_SVH
`define SIGMOID_LUT_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SGLUT_ASSERT_IMP(clk, rst_n, label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sglut same-cycle check failed");

// next-cycle implication, off during reset
`define SGLUT_ASSERT_NEXT(clk, rst_n, label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sglut next-cycle check failed");

// signal low in the cycle after reset is seen
`define SGLUT_ASSERT_RST(clk, rst_n, label, sig) \
  label: assert property (@(posedge clk) (!rst_n) |=> (!(sig))) \
    else $error("sglut reset check failed");

`endif

// ----- src/sglut_pkg.sv -----
package sglut_pkg;

  localparam int HALF_RANGE = 100;
  localparam int SEGMENTS   = 1024;
  localparam int FRAC_BITS  = 16;
  localparam int X_FRAC     = 16;

  localparam int X_W   = 24;
  localparam int IDX_W = 11;
  localparam int VAL_W = 25;

  localparam logic [VAL_W-1:0] ONE_Q24 = VAL_W'(longint'(1) << 24);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // powers of two shared by the segment count and the span
  function automatic int common_twos(longint s);
    int n;
    n = 0;
    for (int i = 0; i < 17; i++) begin
      if ((((s >> i) & 1) == 0) && (n == i)) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  localparam longint LIM   = longint'(HALF_RANGE) << X_FRAC;
  localparam longint SPAN  = 2 * LIM;
  localparam int     TWOS  = common_twos(longint'(SEGMENTS));
  localparam longint SEG_R = longint'(SEGMENTS) >> TWOS;
  localparam longint DIV_R = SPAN >> TWOS;

  localparam int     U_W    = $clog2(SPAN + 1);
  localparam longint V_MAX  = SPAN * SEG_R;
  localparam int     V_W    = $clog2(V_MAX + 1);
  localparam int     REC_SH = V_W;
  localparam longint REC_M  = ((longint'(1) << (FRAC_BITS + V_W)) / DIV_R) + 1;
  localparam int     M_W    = $clog2(REC_M + 1);
  localparam int     DIV_W  = $clog2(DIV_R + 1);

  localparam int TBL_DEPTH = SEGMENTS + 1;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int Q_W       = FRAC_BITS + ADDR_W;

  typedef enum logic [1:0] {
    RNG_INSIDE,
    RNG_BELOW,
    RNG_ABOVE
  } range_t;

  typedef struct packed {
    logic              eval;
    range_t            rng;
    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wval;
  } ctl_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [ADDR_W-1:0]    lo_addr;
    logic [ADDR_W-1:0]    hi_addr;
    logic [FRAC_BITS-1:0] frac;
  } idx_item_t;

  typedef struct packed {
    range_t               rng;
    logic [FRAC_BITS-1:0] frac;
    logic [VAL_W-1:0]     lo;
    logic [VAL_W-1:0]     hi;
  } blend_item_t;

endpackage

// ----- src/sigmoid_lut_interpolator.sv -----
// Sigmoid by table lookup with linear interpolation. Every request carries an
// opcode: a write stores one sample (clamped to 1.0, ignored past the last
// entry) and gives no result; an evaluate takes x in signed Q8.16 and returns
// sigmoid(x) in unsigned Q1.24. A request is taken every cycle while in_stall is
// low; results leave in request order, and both kinds of request travel the
// same pipeline, so a write affects exactly the evaluates issued after it. The
// span division is a reciprocal multiply with a one-step correction over three
// stages, the table is a two-read-port memory read in the fourth, and the blend
// takes the last two. Samples are not cleared by reset: each entry must be
// written before an evaluate can land on it.
module sigmoid_lut_interpolator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic signed [sglut_pkg::X_W-1:0] in_x_value,
  input  logic [sglut_pkg::IDX_W-1:0]      in_entry_index,
  input  logic [sglut_pkg::VAL_W-1:0]      in_entry_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sglut_pkg::VAL_W-1:0]      out_y_value
);

  import sglut_pkg::*;

  logic             idx_in_ready;
  logic             idx_valid;
  logic             idx_ready;
  idx_item_t        idx_item;
  logic             c_fire;
  logic             ram_we, ram_re;
  logic [VAL_W-1:0] lo_data, hi_data;
  logic             d_valid_r;
  logic             d_ready;
  range_t           d_rng_r;
  logic [FRAC_BITS-1:0] d_frac_r;
  logic             bl_in_ready;
  blend_item_t      bl_item;

  sglut_index u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (idx_in_ready),
    .in_eval   (in_opcode == OP_EVAL),
    .in_x      (in_x_value),
    .in_widx   (in_entry_index),
    .in_wval   (in_entry_value),
    .out_valid (idx_valid),
    .out_ready (idx_ready),
    .out_item  (idx_item)
  );

  assign in_stall = !idx_in_ready;

  // table stage: writes land here so they stay in request order
  assign d_ready   = !d_valid_r || bl_in_ready;
  assign idx_ready = d_ready;
  assign c_fire    = idx_valid && d_ready;
  assign ram_we    = c_fire && idx_item.ctl.wr_en;
  assign ram_re    = c_fire && idx_item.ctl.eval;

  sglut_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (idx_item.ctl.waddr),
    .wdata   (idx_item.ctl.wval),
    .re      (ram_re),
    .raddr_a (idx_item.lo_addr),
    .raddr_b (idx_item.hi_addr),
    .rdata_a (lo_data),
    .rdata_b (hi_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_ready) begin
      d_valid_r <= idx_valid && idx_item.ctl.eval;
    end
  end

  always_ff @(posedge clk) begin
    if (c_fire) begin
      d_rng_r  <= idx_item.ctl.rng;
      d_frac_r <= idx_item.frac;
    end
  end

  always_comb begin
    bl_item.rng  = d_rng_r;
    bl_item.frac = d_frac_r;
    bl_item.lo   = lo_data;
    bl_item.hi   = hi_data;
  end

  sglut_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid_r),
    .in_ready  (bl_in_ready),
    .in_item   (bl_item),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_y     (out_y_value)
  );

endmodule

// ----- src/sglut_ram.sv -----
module sglut_ram #(
  parameter int WIDTH = sglut_pkg::VAL_W,
  parameter int DEPTH = sglut_pkg::TBL_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- src/sglut_index.sv -----
module sglut_index (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_eval,
  input  logic signed [sglut_pkg::X_W-1:0] in_x,
  input  logic [sglut_pkg::IDX_W-1:0]    in_widx,
  input  logic [sglut_pkg::VAL_W-1:0]    in_wval,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sglut_pkg::idx_item_t           out_item
);

  import sglut_pkg::*;

  localparam logic signed [X_W:0] LIM_S = (X_W + 1)'(LIM);
  localparam int PROD_W = V_W + M_W;
  localparam int T_W    = Q_W + DIV_W;

  logic signed [X_W:0]  x_ext;
  logic signed [X_W:0]  u_full;
  logic                 below;
  logic                 above;
  ctl_t                 a_ctl_nxt;
  logic [V_W-1:0]       a_v_nxt;
  logic [PROD_W-1:0]    prod;
  logic [Q_W-1:0]       b_q_nxt;
  logic [T_W-1:0]       c_t_nxt;
  logic                 over;
  logic [Q_W-1:0]       q;
  logic [ADDR_W-1:0]    id;

  logic                 a_valid_r, b_valid_r, c_valid_r;
  logic                 a_ready, b_ready, c_ready;
  ctl_t                 a_ctl_r, b_ctl_r, c_ctl_r;
  logic [V_W-1:0]       a_v_r, b_v_r, c_v_r;
  logic [Q_W-1:0]       b_q_r, c_q_r;
  logic [T_W-1:0]       c_t_r;

  assign c_ready  = !c_valid_r || out_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  // range check and offset
  always_comb begin
    x_ext  = {in_x[X_W-1], in_x};
    below  = x_ext < -LIM_S;
    above  = x_ext > LIM_S;
    u_full = x_ext + LIM_S;
    a_ctl_nxt.eval  = in_eval;
    a_ctl_nxt.rng   = below ? RNG_BELOW : (above ? RNG_ABOVE : RNG_INSIDE);
    a_ctl_nxt.wr_en = !in_eval && (32'(in_widx) <= 32'(SEGMENTS));
    a_ctl_nxt.waddr = ADDR_W'(in_widx);
    a_ctl_nxt.wval  = (in_wval > ONE_Q24) ? ONE_Q24 : in_wval;
    if (below || above) begin
      a_v_nxt = '0;
    end else begin
      a_v_nxt = V_W'(u_full[U_W-1:0]) * V_W'(SEG_R);
    end
  end

  // reciprocal estimate of the scaled quotient
  assign prod    = PROD_W'(a_v_r) * PROD_W'(REC_M);
  assign b_q_nxt = Q_W'(prod >> REC_SH);

  assign c_t_nxt = T_W'(b_q_r) * T_W'(DIV_R);

  // estimate is exact or one high
  always_comb begin
    over = 64'(c_t_r) > (64'(c_v_r) << FRAC_BITS);
    q    = over ? (c_q_r - 1'b1) : c_q_r;
    id   = q[Q_W-1:FRAC_BITS];
    out_item.ctl     = c_ctl_r;
    out_item.lo_addr = id;
    out_item.hi_addr = (id == ADDR_W'(SEGMENTS)) ? id : (id + 1'b1);
    out_item.frac    = q[FRAC_BITS-1:0];
  end

  assign out_valid = c_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_ctl_r <= a_ctl_nxt;
      a_v_r   <= a_v_nxt;
    end
    if (b_ready) begin
      b_ctl_r <= a_ctl_r;
      b_v_r   <= a_v_r;
      b_q_r   <= b_q_nxt;
    end
    if (c_ready) begin
      c_ctl_r <= b_ctl_r;
      c_v_r   <= b_v_r;
      c_q_r   <= b_q_r;
      c_t_r   <= c_t_nxt;
    end
  end

endmodule

// ----- src/sglut_blend.sv -----
module sglut_blend (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sglut_pkg::blend_item_t      in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sglut_pkg::VAL_W-1:0] out_y
);

  import sglut_pkg::*;

  localparam int ACC_W = VAL_W + FRAC_BITS + 2;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC_BITS - 1);

  logic signed [VAL_W:0]       diff;
  logic signed [FRAC_BITS:0]   frac_s;
  logic signed [ACC_W-1:0]     e_prod_nxt;
  logic signed [ACC_W-1:0]     acc;
  logic [VAL_W+1:0]            y_full;
  logic [VAL_W-1:0]            y_sat;
  logic [VAL_W-1:0]            out_y_nxt;

  logic                        e_valid_r;
  logic                        out_valid_r;
  logic                        e_ready, o_ready;
  range_t                      e_rng_r;
  logic [VAL_W-1:0]            e_lo_r;
  logic signed [ACC_W-1:0]     e_prod_r;
  logic [VAL_W-1:0]            out_y_r;

  assign o_ready  = !out_valid_r || out_ready;
  assign e_ready  = !e_valid_r || o_ready;
  assign in_ready = e_ready;

  // lo*(1-f) + hi*f written as lo + (hi-lo)*f
  always_comb begin
    diff       = $signed({1'b0, in_item.hi}) - $signed({1'b0, in_item.lo});
    frac_s     = $signed({1'b0, in_item.frac});
    e_prod_nxt = ACC_W'(diff * frac_s);
  end

  always_comb begin
    acc    = $signed({2'b00, e_lo_r, {FRAC_BITS{1'b0}}}) + e_prod_r + RND;
    y_full = acc[ACC_W-1:FRAC_BITS];
    y_sat  = (y_full > (VAL_W + 2)'(ONE_Q24)) ? ONE_Q24 : y_full[VAL_W-1:0];
    case (e_rng_r)
      RNG_BELOW: out_y_nxt = '0;
      RNG_ABOVE: out_y_nxt = ONE_Q24;
      default:   out_y_nxt = y_sat;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_y     = out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (e_ready) begin
        e_valid_r <= in_valid;
      end
      if (o_ready) begin
        out_valid_r <= e_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready) begin
      e_rng_r  <= in_item.rng;
      e_lo_r   <= in_item.lo;
      e_prod_r <= e_prod_nxt;
    end
    if (o_ready) begin
      out_y_r <= out_y_nxt;
    end
  end

endmodule

// ----- src/sglut_checker.sv -----
`include "sigmoid_lut_interpolator_defines.svh"

module sglut_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sglut_pkg::VAL_W-1:0] out_y_value
);

  import sglut_pkg::*;

  // a stalled result stays put
  `SGLUT_ASSERT_NEXT(clk, rst_n, a_out_hold, out_valid && out_stall, out_valid && $stable(out_y_value))

  // results never exceed one
  `SGLUT_ASSERT_IMP(clk, rst_n, a_y_range, out_valid, out_y_value <= ONE_Q24)

  // requests are only held off by a full pipeline behind a stalled result
  `SGLUT_ASSERT_IMP(clk, rst_n, a_stall_cause, in_stall, out_valid && out_stall)

  // reset empties the output stage
  `SGLUT_ASSERT_RST(clk, rst_n, a_rst_empty, out_valid)

endmodule

bind sigmoid_lut_interpolator sglut_checker u_sglut_checker (.*);

// ----- verif/sigmoid_lut_interpolator_tb.sv -----
`timescale 1ns / 1ps

module sigmoid_lut_interpolator_tb;
  import sglut_pkg::*;

  localparam longint X_LIMIT   = longint'(HALF_RANGE) << X_FRAC;
  localparam longint X_SPAN    = 2 * X_LIMIT;
  localparam longint SEG_STEP  = X_SPAN / SEGMENTS;
  localparam longint X_TOP     = (longint'(1) << (X_W - 1)) - 1;
  localparam longint X_BOTTOM  = -(longint'(1) << (X_W - 1));
  localparam int     QUIET_LIMIT = 2000;
  localparam int     RANDOM_REQUESTS = 640;

  typedef struct packed {
    logic                    opcode;
    logic signed [X_W-1:0]   x;
    logic [IDX_W-1:0]        index;
    logic [VAL_W-1:0]        value;
  } sg_request_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_HOLD
  } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = OP_WRITE;
  logic signed [X_W-1:0] in_x_value = '0;
  logic [IDX_W-1:0]      in_entry_index = '0;
  logic [VAL_W-1:0]      in_entry_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VAL_W-1:0]      out_y_value;

  sg_request_t      pending_requests[$];
  logic [VAL_W-1:0] expected_y[$];
  logic [VAL_W-1:0] lut_model [0:SEGMENTS];
  bit               loaded [0:SEGMENTS];

  int          send_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          mismatch_cnt = 0;
  int          quiet_cycles = 0;

  sigmoid_lut_interpolator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_x_value     (in_x_value),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_y_value    (out_y_value)
  );

  always #1 clk = ~clk;

  function automatic logic [VAL_W-1:0] interp_sigmoid(logic signed [X_W-1:0] x);
    longint xv, u, p, seg, rem, frac, lo, hi, acc;
    xv = x;
    if (xv < -X_LIMIT) return '0;
    if (xv > X_LIMIT) return ONE_Q24;
    u = xv + X_LIMIT;
    p = u * SEGMENTS;
    seg = p / X_SPAN;
    rem = p % X_SPAN;
    if (seg >= SEGMENTS) return lut_model[SEGMENTS];
    frac = (rem << FRAC_BITS) / X_SPAN;
    lo = longint'(lut_model[seg]);
    hi = longint'(lut_model[seg + 1]);
    acc = lo * ((longint'(1) << FRAC_BITS) - frac) + hi * frac
          + (longint'(1) << (FRAC_BITS - 1));
    acc = acc >>> FRAC_BITS;
    if (acc > longint'(ONE_Q24)) acc = longint'(ONE_Q24);
    return VAL_W'(acc);
  endfunction

  function automatic void apply_request(sg_request_t r);
    logic [VAL_W-1:0] v;
    if (r.opcode == OP_WRITE) begin
      v = (r.value > ONE_Q24) ? ONE_Q24 : r.value;
      if (r.index <= SEGMENTS) lut_model[r.index] = v;
    end else begin
      expected_y.insert(expected_y.size(), interp_sigmoid(r.x));
    end
  endfunction

  function automatic void push_write(int idx, logic [VAL_W-1:0] val);
    sg_request_t r;
    r.opcode = OP_WRITE;
    r.x      = X_W'($urandom);
    r.index  = IDX_W'(idx);
    r.value  = val;
    if (idx <= SEGMENTS) loaded[idx] = 1'b1;
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic void push_eval(longint xv);
    sg_request_t r;
    r.opcode = OP_EVAL;
    r.x      = X_W'(xv);
    r.index  = IDX_W'($urandom);
    r.value  = VAL_W'($urandom);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic void report_mismatch(string what, logic [VAL_W-1:0] want,
                                          logic [VAL_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s y_value expected %0d actual %0d", $time, what, want, got);
  endfunction

  // request driver
  always @(posedge clk) begin
    sg_request_t nxt;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_left <= 0;
      gap_left  <= 0;
    end else begin
      if (in_valid && !in_stall)
        apply_request('{in_opcode, in_x_value, in_entry_index, in_entry_value});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          nxt = pending_requests.pop_front();
          in_opcode      <= nxt.opcode;
          in_x_value     <= nxt.x;
          in_entry_index <= nxt.index;
          in_entry_value <= nxt.value;
          in_valid       <= 1'b1;
          if (send_left > 1) begin
            send_left <= send_left - 1;
          end else begin
            send_left <= $urandom_range(1, 32);
            gap_left  <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= STALL_NONE;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(5, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b1;
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_y.size() == 0) begin
        report_mismatch("unexpected result,", '0, out_y_value);
      end else begin
        want = expected_y.pop_front();
        if (out_y_value !== want) report_mismatch("mismatch,", want, out_y_value);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sigmoid_lut_interpolator test failed");
      $finish;
    end
  end

  initial begin
    int roll, seg, base, k, idx, last_idx;
    longint r;
    logic [VAL_W-1:0] val;

    for (int i = 0; i <= SEGMENTS; i++) loaded[i] = 1'b0;

    push_write(0, '0);
    push_write(1, '1);
    push_write(SEGMENTS, ONE_Q24);
    push_write(SEGMENTS - 1, ONE_Q24 - 1);
    push_write((1 << IDX_W) - 1, VAL_W'(12345));
    push_write(SEGMENTS + 1, '0);
    push_write(2, VAL_W'(1 << 23));
    push_eval(-X_LIMIT);
    push_eval(-X_LIMIT - 1);
    push_eval(X_BOTTOM);
    push_eval(X_TOP);
    push_eval(X_LIMIT + 1);
    push_eval(X_LIMIT);
    push_eval(X_LIMIT - 1);
    push_eval(-X_LIMIT + SEG_STEP / 2);
    push_eval(-X_LIMIT + SEG_STEP - 1);
    push_eval(-X_LIMIT + SEG_STEP);
    push_eval(-X_LIMIT + SEG_STEP + 1);
    push_write(0, VAL_W'(1));
    push_eval(-X_LIMIT + 1);
    push_eval(X_LIMIT - SEG_STEP);

    last_idx = 2;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: idx = $urandom_range(0, SEGMENTS);
          4, 5, 6, 7: idx = (last_idx >= SEGMENTS) ? 0 : last_idx + 1;
          8:          idx = ($urandom_range(0, 1) == 0) ? 0 : SEGMENTS;
          default:    idx = $urandom_range(SEGMENTS + 1, (1 << IDX_W) - 1);
        endcase
        case ($urandom_range(0, 9))
          0:       val = '0;
          1:       val = ONE_Q24;
          2:       val = VAL_W'($urandom_range(32'h100_0001, 32'h1FF_FFFF));
          default: val = VAL_W'($urandom_range(0, 32'h100_0000));
        endcase
        if (idx <= SEGMENTS) last_idx = idx;
        push_write(idx, val);
      end else begin
        seg = -1;
        if (roll >= 45) begin
          base = $urandom_range(0, SEGMENTS);
          for (int i = 0; i <= SEGMENTS && seg < 0; i++) begin
            k = (base + i) % (SEGMENTS + 1);
            if ((k == SEGMENTS) ? loaded[k] : (loaded[k] && loaded[k + 1])) seg = k;
          end
        end
        if (seg == SEGMENTS) begin
          push_eval(X_LIMIT);
        end else if (seg >= 0) begin
          case ($urandom_range(0, 7))
            0:       r = 0;
            1:       r = SEG_STEP - 1;
            2:       r = SEG_STEP / 2;
            default: r = $urandom_range(0, SEG_STEP - 1);
          endcase
          push_eval(seg * SEG_STEP + r - X_LIMIT);
        end else if ($urandom_range(0, 1) == 0) begin
          push_eval(-X_LIMIT - 1 - longint'($urandom_range(0, -X_LIMIT - 1 - X_BOTTOM)));
        end else begin
          push_eval(X_LIMIT + 1 + longint'($urandom_range(0, X_TOP - X_LIMIT - 1)));
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_y.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_cnt == 0 && expected_y.size() == 0) begin
      $display("sigmoid_lut_interpolator test passed");
    end else begin
      $display("sigmoid_lut_interpolator test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/sglut_pkg.sv
src/sglut_ram.sv
src/sglut_index.sv
src/sglut_blend.sv
src/sigmoid_lut_interpolator.sv
src/sglut_checker.sv
verif/sigmoid_lut_interpolator_tb.sv
